// ===== rtl/jsu_pkg.sv =====
// Shared types and constants for the JSON string unescaper.
// Holds the parse phase codes, event codes and the decoded-job record.
// No dependencies.
package jsu_pkg;

   // Request kinds
   localparam logic [1:0] KIND_BYTE  = 2'd0;
   localparam logic [1:0] KIND_START = 2'd1;
   localparam logic [1:0] KIND_END   = 2'd2;

   // Parse phases
   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_BODY   = 3'd1;
   localparam logic [2:0] PH_ESC    = 3'd2;
   localparam logic [2:0] PH_HEX1   = 3'd3;
   localparam logic [2:0] PH_NEEDBS = 3'd4;
   localparam logic [2:0] PH_NEEDU  = 3'd5;
   localparam logic [2:0] PH_HEX2   = 3'd6;

   // Result events
   localparam logic [3:0] EV_BYTE    = 4'd0;
   localparam logic [3:0] EV_DONE    = 4'd1;
   localparam logic [3:0] EV_NOQUOTE = 4'd2;
   localparam logic [3:0] EV_UNTERM  = 4'd3;
   localparam logic [3:0] EV_CONTROL = 4'd4;
   localparam logic [3:0] EV_ESCAPE  = 4'd5;
   localparam logic [3:0] EV_HEX     = 4'd6;
   localparam logic [3:0] EV_HIGH    = 4'd7;
   localparam logic [3:0] EV_LOW     = 4'd8;
   localparam logic [3:0] EV_NUL     = 4'd9;

   // Characters the parser looks for
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_U     = 8'h75;
   localparam logic [7:0] CH_SPACE = 8'h20;

   // Letters of the single-character escapes
   localparam logic [7:0] CH_LB = 8'h62;
   localparam logic [7:0] CH_LF = 8'h66;
   localparam logic [7:0] CH_LN = 8'h6E;
   localparam logic [7:0] CH_LR = 8'h72;
   localparam logic [7:0] CH_LT = 8'h74;

   // Job queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // One decoded job: up to four result bytes, or a single event
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [1:0]      last_idx;
      logic [3:0]      ev;
   } job_type;

   // Queue status seen by front and back
   typedef struct packed {
      logic full;
      logic valid;
   } q_status_type;

endpackage

// ===== rtl/jsu_if.sv =====
// Valid/ready channel interfaces for request and response traffic.
// No dependencies.
interface jsu_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] data_byte;

   modport source (output valid, output kind, output data_byte, input ready);
   modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface jsu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic [3:0] event_res;
   logic       last;

   modport source (output valid, output out_byte, output event_res, output last, input ready);
   modport sink   (input valid, input out_byte, input event_res, input last, output ready);
endinterface

// ===== rtl/jsu_front.sv =====
// Front end: accepts requests, tracks the parse phase and turns each request
// into at most one job of result bytes or an event. Uses jsu_pkg, jsu_req_if.
module jsu_front (
   input  logic                 clock,
   input  logic                 reset,
   jsu_req_if.sink              req_chan,
   input  jsu_pkg::q_status_type q_status,
   output logic                 job_push,
   output jsu_pkg::job_type     job
);
   import jsu_pkg::*;

   logic [2:0]  phase_ff,  phase_in;
   logic [1:0]  digits_ff, digits_in;
   logic [15:0] hex_ff,    hex_in;
   logic [9:0]  high_ff,   high_in;
   logic        job_valid;
   logic        accept;
   logic [4:0]  hex_dig;
   logic [15:0] hex_full;
   logic [20:0] pair_cp;

   // Decode one hex digit: bit 4 flags a bad digit
   function automatic logic [4:0] hex_of(input logic [7:0] b);
      logic [4:0] r;
      r = 5'h10;
      if (b >= 8'h30 && b <= 8'h39) r = {1'b0, 4'(b - 8'h30)};
      else if (b >= 8'h61 && b <= 8'h66) r = {1'b0, 4'(b - 8'h57)};
      else if (b >= 8'h41 && b <= 8'h46) r = {1'b0, 4'(b - 8'h37)};
      return r;
   endfunction

   // Encode a code point as one to four UTF-8 bytes
   function automatic job_type encode_cp(input logic [20:0] cp);
      job_type j;
      j = '0;
      j.ev = EV_BYTE;
      if (cp < 21'h80) begin
         j.bytes[0] = cp[7:0];
         j.last_idx = 2'd0;
      end else if (cp < 21'h800) begin
         j.bytes[0] = {3'b110, cp[10:6]};
         j.bytes[1] = {2'b10, cp[5:0]};
         j.last_idx = 2'd1;
      end else if (cp < 21'h10000) begin
         j.bytes[0] = {4'b1110, cp[15:12]};
         j.bytes[1] = {2'b10, cp[11:6]};
         j.bytes[2] = {2'b10, cp[5:0]};
         j.last_idx = 2'd2;
      end else begin
         j.bytes[0] = {5'b11110, cp[20:18]};
         j.bytes[1] = {2'b10, cp[17:12]};
         j.bytes[2] = {2'b10, cp[11:6]};
         j.bytes[3] = {2'b10, cp[5:0]};
         j.last_idx = 2'd3;
      end
      return j;
   endfunction

   // Accept whenever the job queue has room
   assign req_chan.ready = !q_status.full;
   assign accept         = req_chan.valid && req_chan.ready;
   assign job_push       = accept && job_valid;

   assign hex_dig  = hex_of(req_chan.data_byte);
   assign hex_full = {hex_ff[11:0], hex_dig[3:0]};
   assign pair_cp  = 21'h10000 + {1'b0, high_ff, hex_full[9:0]};

   // Work out the next phase and the job for this request
   always_comb begin
      phase_in  = phase_ff;
      digits_in = digits_ff;
      hex_in    = hex_ff;
      high_in   = high_ff;
      job_valid = 1'b0;
      job       = '0;
      job.ev    = EV_BYTE;
      if (req_chan.kind == KIND_START) begin
         if (req_chan.data_byte == CH_QUOTE) begin
            phase_in  = PH_BODY;
            digits_in = '0;
            hex_in    = '0;
            high_in   = '0;
         end else begin
            phase_in  = PH_IDLE;
            job_valid = 1'b1;
            job.ev    = EV_NOQUOTE;
         end
      end else if (req_chan.kind == KIND_END) begin
         if (phase_ff != PH_IDLE) begin
            phase_in  = PH_IDLE;
            job_valid = 1'b1;
            unique case (phase_ff)
               PH_BODY:          job.ev = EV_UNTERM;
               PH_ESC:           job.ev = EV_ESCAPE;
               PH_HEX1, PH_HEX2: job.ev = EV_HEX;
               default:          job.ev = EV_HIGH;
            endcase
         end
      end else if (req_chan.kind == KIND_BYTE) begin
         unique case (phase_ff)
            PH_IDLE: begin
            end
            PH_BODY: begin
               job_valid = 1'b1;
               if (req_chan.data_byte == CH_QUOTE) begin
                  phase_in = PH_IDLE;
                  job.ev   = EV_DONE;
               end else if (req_chan.data_byte < CH_SPACE) begin
                  phase_in = PH_IDLE;
                  job.ev   = EV_CONTROL;
               end else if (req_chan.data_byte == CH_BSL) begin
                  phase_in  = PH_ESC;
                  job_valid = 1'b0;
               end else begin
                  job.bytes[0] = req_chan.data_byte;
               end
            end
            PH_ESC: begin
               job_valid = 1'b1;
               phase_in  = PH_BODY;
               unique case (req_chan.data_byte)
                  CH_QUOTE, CH_BSL, CH_SLASH: job.bytes[0] = req_chan.data_byte;
                  CH_LB: job.bytes[0] = 8'h08;
                  CH_LF: job.bytes[0] = 8'h0C;
                  CH_LN: job.bytes[0] = 8'h0A;
                  CH_LR: job.bytes[0] = 8'h0D;
                  CH_LT: job.bytes[0] = 8'h09;
                  CH_U: begin
                     job_valid = 1'b0;
                     phase_in  = PH_HEX1;
                     digits_in = '0;
                     hex_in    = '0;
                  end
                  default: begin
                     phase_in = PH_IDLE;
                     job.ev   = EV_ESCAPE;
                  end
               endcase
            end
            PH_NEEDBS: begin
               if (req_chan.data_byte == CH_BSL) begin
                  phase_in = PH_NEEDU;
               end else begin
                  phase_in  = PH_IDLE;
                  job_valid = 1'b1;
                  job.ev    = EV_HIGH;
               end
            end
            PH_NEEDU: begin
               if (req_chan.data_byte == CH_U) begin
                  phase_in  = PH_HEX2;
                  digits_in = '0;
                  hex_in    = '0;
               end else begin
                  phase_in  = PH_IDLE;
                  job_valid = 1'b1;
                  job.ev    = EV_HIGH;
               end
            end
            PH_HEX1, PH_HEX2: begin
               if (hex_dig[4]) begin
                  phase_in  = PH_IDLE;
                  job_valid = 1'b1;
                  job.ev    = EV_HEX;
               end else begin
                  hex_in = hex_full;
                  if (digits_ff != 2'd3) begin
                     digits_in = digits_ff + 2'd1;
                  end else begin
                     digits_in = '0;
                     if (phase_ff == PH_HEX1) begin
                        if (hex_full[15:10] == 6'b110110) begin
                           high_in  = hex_full[9:0];
                           phase_in = PH_NEEDBS;
                        end else if (hex_full[15:10] == 6'b110111) begin
                           phase_in  = PH_IDLE;
                           job_valid = 1'b1;
                           job.ev    = EV_LOW;
                        end else if (hex_full == 16'h0000) begin
                           phase_in  = PH_IDLE;
                           job_valid = 1'b1;
                           job.ev    = EV_NUL;
                        end else begin
                           phase_in  = PH_BODY;
                           job_valid = 1'b1;
                           job       = encode_cp({5'b0, hex_full});
                        end
                     end else begin
                        job_valid = 1'b1;
                        if (hex_full[15:10] == 6'b110111) begin
                           phase_in = PH_BODY;
                           job      = encode_cp(pair_cp);
                        end else begin
                           phase_in = PH_IDLE;
                           job.ev   = EV_HIGH;
                        end
                     end
                  end
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   // Advance parse state on each accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         digits_ff <= '0;
         hex_ff    <= '0;
         high_ff   <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         digits_ff <= digits_in;
         hex_ff    <= hex_in;
         high_ff   <= high_in;
      end
   end

   // Parser never leaves the defined phases
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= PH_HEX2)
      else $error("parse phase out of range");

endmodule

// ===== rtl/jsu_queue.sv =====
// Short job queue between front and back; registered entries, one push and
// one pop per cycle. Uses jsu_pkg.
module jsu_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  jsu_pkg::job_type      push_job,
   input  logic                  pop,
   output jsu_pkg::job_type      head_job,
   output jsu_pkg::q_status_type status
);
   import jsu_pkg::*;

   job_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff,  count_in;
   logic              do_pop;

   assign status.full  = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign status.valid = (count_ff != '0);
   assign head_job     = mem_ff[rd_ptr_ff];
   assign do_pop       = pop && status.valid;

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed jobs
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full)
      else $error("push into full job queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QPTR_W + 1)'(QUEUE_DEPTH))
      else $error("job queue count out of range");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("job queue count did not follow push");

endmodule

// ===== rtl/jsu_back.sv =====
// Back end: walks the head job one byte per response and pops it after the
// last one. Uses jsu_pkg, jsu_rsp_if.
module jsu_back (
   input  logic                  clock,
   input  logic                  reset,
   input  jsu_pkg::job_type      head_job,
   input  jsu_pkg::q_status_type q_status,
   output logic                  pop,
   jsu_rsp_if.source             rsp_chan
);
   import jsu_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       at_last;
   logic       fire;

   assign at_last            = (idx_ff == head_job.last_idx);
   assign rsp_chan.valid     = q_status.valid;
   assign rsp_chan.out_byte  = head_job.bytes[idx_ff];
   assign rsp_chan.event_res = head_job.ev;
   assign rsp_chan.last      = at_last;
   assign fire               = rsp_chan.valid && rsp_chan.ready;
   assign pop                = fire && at_last;

   // Step through the job's bytes, rewind on pop
   always_comb begin
      idx_in = idx_ff;
      if (fire) begin
         idx_in = at_last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (idx_ff <= head_job.last_idx))
      else $error("byte index past end of job");

   a_event_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.event_res != EV_BYTE) |-> rsp_chan.last)
      else $error("event response not marked last");

endmodule

// ===== rtl/json_string_unescape_utf8.sv =====
// JSON string unescaper, top level: front parser, job queue and back end.
// Uses jsu_pkg, jsu_req_if, jsu_rsp_if, jsu_front, jsu_queue, jsu_back.
//
// Usage:
//   req_chan carries one byte of a JSON string literal per request: kind
//   START with the opening quote, then BYTE for each following byte, and
//   END when input runs out. rsp_chan returns the decoded UTF-8 bytes
//   (event 0), or one done/error event; last marks the final response of
//   each request. Requests that produce nothing return no response.
// Timing:
//   A request is parsed in the cycle it is accepted and its job is
//   registered into a four-entry queue, whose head job the back end
//   presents. Responses drain one per cycle while rsp_chan.ready is high;
//   a job yields one to four responses. Requests are taken back to back
//   while the queue has room.
// Reset:
//   Synchronous reset returns the parser to idle and empties the queue.
// Stall:
//   When rsp_chan is held off, jobs collect in the queue; once it is full
//   req_chan.ready drops until a job is drained.
module json_string_unescape_utf8 (
   input  logic      clock,
   input  logic      reset,
   jsu_req_if.sink   req_chan,
   jsu_rsp_if.source rsp_chan
);
   import jsu_pkg::*;

   job_type      push_job;
   job_type      head_job;
   q_status_type q_status;
   logic         push;
   logic         pop;

   // Parse requests into jobs
   jsu_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_status (q_status),
      .job_push (push),
      .job      (push_job)
   );

   // Hold jobs between parser and response side
   jsu_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (q_status)
   );

   // Send job bytes as responses
   jsu_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_job (head_job),
      .q_status (q_status),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== verif/json_string_unescape_utf8_test.sv =====
// Self-checking testbench for the JSON string unescaper json_string_unescape_utf8.
// Drives string literal bytes with random idles, predicts the UTF-8 bytes and events, checks them.
// Depends on jsu_pkg, jsu_req_if, jsu_rsp_if and json_string_unescape_utf8 from the RTL.
module json_string_unescape_utf8_test;
   import jsu_pkg::*;

   // Reserved request kind, ignored by the block
   localparam logic [1:0] KIND_RSVD = 2'd3;

   localparam int RANDOM_REQS = 400;
   localparam int END_SETTLE  = 20;
   localparam int RUN_LIMIT   = 10_000_000;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
      logic       hold;
   } req_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [3:0] event_res;
      logic       last;
   } decoded_item_type;

   logic clock;
   logic reset;

   jsu_req_if req_chan ();
   jsu_rsp_if rsp_chan ();

   json_string_unescape_utf8 dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   req_item_type     pending_reqs[$];
   decoded_item_type decoded_q[$];
   req_item_type     next_req;
   decoded_item_type got;
   decoded_item_type want;
   int               error_count = 0;
   int               send_gap = 0;
   int               drain_gap = 0;
   bit               send_steady = 1'b0;
   bit               drain_steady = 1'b0;

   // Parser state of the predictor
   logic [2:0]  parse_phase = PH_IDLE;
   logic [1:0]  hex_count = 2'd0;
   logic [15:0] hex_acc = 16'd0;
   logic [9:0]  high_bits = 10'd0;

   string SIMPLE_ESC = "\"\\/bfnrt";
   string HEX_CHARS  = "0123456789abcdefABCDEF";

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hex digit value, or 16 when the byte is not a hex digit
   function automatic logic [4:0] nibble_value(logic [7:0] c);
      if (c >= "0" && c <= "9") return {1'b0, c[3:0]};
      if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) return {1'b0, c[3:0] + 4'd9};
      return 5'h10;
   endfunction

   function automatic void push_decoded(logic [7:0] b, logic [3:0] ev);
      decoded_item_type d;
      d.out_byte  = b;
      d.event_res = ev;
      d.last      = 1'b0;
      decoded_q.push_back(d);
   endfunction

   // Report an error and drop to idle
   function automatic void stop_with(logic [3:0] ev);
      parse_phase = PH_IDLE;
      push_decoded(8'h00, ev);
   endfunction

   function automatic void encode_utf8(logic [20:0] cp);
      if (cp < 21'h80) begin
         push_decoded(cp[7:0], EV_BYTE);
      end else if (cp < 21'h800) begin
         push_decoded({3'b110, cp[10:6]}, EV_BYTE);
         push_decoded({2'b10, cp[5:0]}, EV_BYTE);
      end else if (cp < 21'h10000) begin
         push_decoded({4'b1110, cp[15:12]}, EV_BYTE);
         push_decoded({2'b10, cp[11:6]}, EV_BYTE);
         push_decoded({2'b10, cp[5:0]}, EV_BYTE);
      end else begin
         push_decoded({5'b11110, cp[20:18]}, EV_BYTE);
         push_decoded({2'b10, cp[17:12]}, EV_BYTE);
         push_decoded({2'b10, cp[11:6]}, EV_BYTE);
         push_decoded({2'b10, cp[5:0]}, EV_BYTE);
      end
   endfunction

   // Advance the predictor by one accepted request and queue what it decodes
   function automatic void unescape_step(logic [1:0] kind, logic [7:0] b);
      int         base;
      logic [4:0] d;
      base = decoded_q.size();
      if (kind == KIND_START) begin
         if (b == CH_QUOTE) begin
            parse_phase = PH_BODY;
            hex_count   = 2'd0;
            hex_acc     = 16'd0;
            high_bits   = 10'd0;
         end else begin
            stop_with(EV_NOQUOTE);
         end
      end else if (kind == KIND_END && parse_phase != PH_IDLE) begin
         case (parse_phase)
            PH_BODY:          stop_with(EV_UNTERM);
            PH_ESC:           stop_with(EV_ESCAPE);
            PH_HEX1, PH_HEX2: stop_with(EV_HEX);
            default:          stop_with(EV_HIGH);
         endcase
      end else if (kind == KIND_BYTE && parse_phase != PH_IDLE) begin
         case (parse_phase)
            PH_BODY: begin
               if (b == CH_QUOTE) begin
                  parse_phase = PH_IDLE;
                  push_decoded(8'h00, EV_DONE);
               end else if (b < CH_SPACE) begin
                  stop_with(EV_CONTROL);
               end else if (b == CH_BSL) begin
                  parse_phase = PH_ESC;
               end else begin
                  push_decoded(b, EV_BYTE);
               end
            end
            PH_ESC: begin
               parse_phase = PH_BODY;
               case (b)
                  CH_QUOTE, CH_BSL, CH_SLASH: push_decoded(b, EV_BYTE);
                  CH_LB: push_decoded(8'h08, EV_BYTE);
                  CH_LF: push_decoded(8'h0C, EV_BYTE);
                  CH_LN: push_decoded(8'h0A, EV_BYTE);
                  CH_LR: push_decoded(8'h0D, EV_BYTE);
                  CH_LT: push_decoded(8'h09, EV_BYTE);
                  CH_U: begin
                     parse_phase = PH_HEX1;
                     hex_count   = 2'd0;
                     hex_acc     = 16'd0;
                  end
                  default: stop_with(EV_ESCAPE);
               endcase
            end
            PH_NEEDBS: begin
               if (b == CH_BSL) parse_phase = PH_NEEDU;
               else stop_with(EV_HIGH);
            end
            PH_NEEDU: begin
               if (b == CH_U) begin
                  parse_phase = PH_HEX2;
                  hex_count   = 2'd0;
                  hex_acc     = 16'd0;
               end else begin
                  stop_with(EV_HIGH);
               end
            end
            PH_HEX1, PH_HEX2: begin
               d = nibble_value(b);
               if (d[4]) begin
                  stop_with(EV_HEX);
               end else begin
                  hex_acc = {hex_acc[11:0], d[3:0]};
                  if (hex_count != 2'd3) begin
                     hex_count = hex_count + 2'd1;
                  end else begin
                     hex_count = 2'd0;
                     if (parse_phase == PH_HEX1) begin
                        // High surrogate waits for its partner
                        if (hex_acc >= 16'hD800 && hex_acc <= 16'hDBFF) begin
                           high_bits   = hex_acc[9:0];
                           parse_phase = PH_NEEDBS;
                        end else if (hex_acc >= 16'hDC00 && hex_acc <= 16'hDFFF) begin
                           stop_with(EV_LOW);
                        end else if (hex_acc == 16'h0000) begin
                           stop_with(EV_NUL);
                        end else begin
                           parse_phase = PH_BODY;
                           encode_utf8({5'd0, hex_acc});
                        end
                     end else if (hex_acc < 16'hDC00 || hex_acc > 16'hDFFF) begin
                        stop_with(EV_HIGH);
                     end else begin
                        parse_phase = PH_BODY;
                        encode_utf8(21'h10000 + {1'b0, high_bits, hex_acc[9:0]});
                     end
                  end
               end
            end
            default: parse_phase = PH_IDLE;
         endcase
      end
      if (decoded_q.size() > base) decoded_q[decoded_q.size() - 1].last = 1'b1;
   endfunction

   // Idle length: mostly none, some short, a few long
   function automatic int pick_gap(bit steady);
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic void push_req(logic [1:0] kind, logic [7:0] b, logic hold);
      req_item_type item;
      item.kind      = kind;
      item.data_byte = b;
      item.hold      = hold;
      pending_reqs.push_back(item);
   endfunction

   function automatic void push_text(string s);
      for (int i = 0; i < s.len(); i++) push_req(KIND_BYTE, s[i], 1'b0);
   endfunction

   function automatic void push_hex_chars(int n);
      repeat (n) push_req(KIND_BYTE, HEX_CHARS[$urandom_range(0, 21)], 1'b0);
   endfunction

   // Queue a \u escape of the given value, letter digits in random case
   function automatic void push_uesc(logic [15:0] v);
      logic [3:0] nib;
      push_req(KIND_BYTE, CH_BSL, 1'b0);
      push_req(KIND_BYTE, CH_U, 1'b0);
      for (int i = 3; i >= 0; i--) begin
         nib = v[i*4 +: 4];
         if (nib < 4'd10) push_req(KIND_BYTE, {4'h3, nib}, 1'b0);
         else push_req(KIND_BYTE, {($urandom_range(0, 1) != 0) ? 4'h6 : 4'h4, nib - 4'd9}, 1'b0);
      end
   endfunction

   // Present requests; predict each one at the edge it is accepted
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            unescape_step(req_chan.kind, req_chan.data_byte);
         if (!req_chan.valid || req_chan.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_chan.valid <= 1'b0;
            end else if (pending_reqs.size() != 0 &&
                         !(pending_reqs[0].hold && decoded_q.size() != 0)) begin
               next_req = pending_reqs.pop_front();
               req_chan.valid     <= 1'b1;
               req_chan.kind      <= next_req.kind;
               req_chan.data_byte <= next_req.data_byte;
               if ($urandom_range(0, 39) == 0) send_steady = !send_steady;
               send_gap = pick_gap(send_steady);
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Take responses with random stalls and check them against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         drain_gap = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.out_byte  = rsp_chan.out_byte;
            got.event_res = rsp_chan.event_res;
            got.last      = rsp_chan.last;
            if (decoded_q.size() == 0) begin
               error_count++;
               $display("%0t: unexpected response byte=%h event=%0d last=%b",
                        $time, got.out_byte, got.event_res, got.last);
            end else begin
               want = decoded_q.pop_front();
               if (got.out_byte !== want.out_byte || got.event_res !== want.event_res ||
                   got.last !== want.last) begin
                  error_count++;
                  $display({"%0t: expected byte=%h event=%0d last=%b, ",
                            "actual byte=%h event=%0d last=%b"},
                           $time, want.out_byte, want.event_res, want.last,
                           got.out_byte, got.event_res, got.last);
               end
            end
         end
         if (drain_gap > 0) begin
            drain_gap--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
            if ($urandom_range(0, 39) == 0) drain_steady = !drain_steady;
            drain_gap = pick_gap(drain_steady);
         end
      end
   end

   initial begin
      #(RUN_LIMIT);
      $display("json_string_unescape_utf8_test: errors");
      $finish;
   end

   // Build the request stream, release reset, then wait for the last response
   initial begin : stimulus
      int          directed_n;
      int          idx;
      logic [7:0]  b;
      logic [15:0] v;
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.kind      = KIND_BYTE;
      req_chan.data_byte = 8'h00;
      rsp_chan.ready     = 1'b0;

      // Idle traffic, reserved kind, start without a quote
      push_req(KIND_BYTE, "a", 1'b0);
      push_req(KIND_END, 8'h00, 1'b0);
      push_req(KIND_RSVD, 8'hFF, 1'b0);
      push_req(KIND_START, 8'h00, 1'b0);
      // Extreme raw byte, reserved kind mid-string, all simple escapes
      push_req(KIND_START, CH_QUOTE, 1'b0);
      push_req(KIND_BYTE, 8'hFF, 1'b0);
      push_req(KIND_RSVD, 8'h00, 1'b0);
      push_text("\\\"\\\\\\/\\b\\f\\n\\r\\t");
      // Largest surrogate pair, then close
      push_text("\\uDBFF\\uDFFF\"");
      // NUL code point
      push_req(KIND_START, CH_QUOTE, 1'b0);
      push_text("\\u0000");
      // Largest BMP value, then a lone low surrogate
      push_req(KIND_START, CH_QUOTE, 1'b0);
      push_text("\\uffff\\udc00");
      // Restart while busy, then a control byte
      push_req(KIND_START, CH_QUOTE, 1'b0);
      push_req(KIND_START, CH_QUOTE, 1'b0);
      push_req(KIND_BYTE, 8'h1F, 1'b0);
      // Input ends inside the body
      push_req(KIND_START, CH_QUOTE, 1'b0);
      push_req(KIND_END, 8'hFF, 1'b0);
      directed_n = pending_reqs.size();

      // Mostly well-formed strings with random content, some noise and broken ones
      while (pending_reqs.size() < directed_n + RANDOM_REQS) begin
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 4))
               push_req(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), 1'b0);
         end else begin
            b = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255)) : CH_QUOTE;
            push_req(KIND_START, b,
                     (pending_reqs.size() == directed_n) || ($urandom_range(0, 24) == 0));
            repeat ($urandom_range(1, 8)) begin
               case ($urandom_range(0, 19))
                  0, 1, 2, 3, 4, 5, 6, 7: begin
                     b = 8'($urandom_range(32, 255));
                     if (b == CH_QUOTE || b == CH_BSL) b = "a";
                     push_req(KIND_BYTE, b, 1'b0);
                  end
                  8: push_req(KIND_BYTE, 8'($urandom_range(0, 31)), 1'b0);
                  9, 10: begin
                     idx = $urandom_range(0, 7);
                     push_req(KIND_BYTE, CH_BSL, 1'b0);
                     push_req(KIND_BYTE, SIMPLE_ESC[idx], 1'b0);
                  end
                  11, 12: begin
                     v = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(1, 16'hD7FF))
                                                     : 16'($urandom());
                     push_uesc(v);
                  end
                  13, 14: begin
                     push_uesc(16'hD800 | 16'($urandom_range(0, 1023)));
                     push_uesc(16'hDC00 | 16'($urandom_range(0, 1023)));
                  end
                  15: begin
                     // High surrogate with a partner that is usually malformed
                     push_uesc(16'hD800 | 16'($urandom_range(0, 1023)));
                     case ($urandom_range(0, 2))
                        0: push_req(KIND_BYTE, 8'($urandom_range(32, 255)), 1'b0);
                        1: begin
                           push_req(KIND_BYTE, CH_BSL, 1'b0);
                           push_req(KIND_BYTE, 8'($urandom_range(0, 255)), 1'b0);
                        end
                        default: push_uesc(16'($urandom()));
                     endcase
                  end
                  16: begin
                     push_req(KIND_BYTE, CH_BSL, 1'b0);
                     push_req(KIND_BYTE, 8'($urandom_range(0, 255)), 1'b0);
                  end
                  17: begin
                     // Bad hex digit after zero to three good ones
                     push_req(KIND_BYTE, CH_BSL, 1'b0);
                     push_req(KIND_BYTE, CH_U, 1'b0);
                     push_hex_chars($urandom_range(0, 3));
                     do b = 8'($urandom_range(0, 255)); while (nibble_value(b) != 5'h10);
                     push_req(KIND_BYTE, b, 1'b0);
                  end
                  18: push_req(KIND_RSVD, 8'($urandom_range(0, 255)), 1'b0);
                  default: begin
                     // Cut an escape short with end of input
                     case ($urandom_range(0, 3))
                        0: push_req(KIND_BYTE, CH_BSL, 1'b0);
                        1: begin
                           push_req(KIND_BYTE, CH_BSL, 1'b0);
                           push_req(KIND_BYTE, CH_U, 1'b0);
                           push_hex_chars($urandom_range(0, 3));
                        end
                        2: push_uesc(16'hD800 | 16'($urandom_range(0, 1023)));
                        default: begin
                           push_uesc(16'hD800 | 16'($urandom_range(0, 1023)));
                           push_req(KIND_BYTE, CH_BSL, 1'b0);
                           if ($urandom_range(0, 1) != 0) begin
                              push_req(KIND_BYTE, CH_U, 1'b0);
                              push_hex_chars($urandom_range(0, 3));
                           end
                        end
                     endcase
                     push_req(KIND_END, 8'($urandom_range(0, 255)), 1'b0);
                  end
               endcase
            end
            // Close the string, end the input, leave it open, or close and add a stray byte
            case ($urandom_range(0, 19))
               16, 17: push_req(KIND_END, 8'($urandom_range(0, 255)), 1'b0);
               18: ;
               19: begin
                  push_req(KIND_BYTE, CH_QUOTE, 1'b0);
                  push_req(KIND_BYTE, 8'($urandom_range(0, 255)), 1'b0);
               end
               default: push_req(KIND_BYTE, CH_QUOTE, 1'b0);
            endcase
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() != 0 || req_chan.valid) @(posedge clock);
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (END_SETTLE) @(posedge clock);

      if (error_count == 0) $display("json_string_unescape_utf8_test: clean");
      else $display("json_string_unescape_utf8_test: errors");
      $finish;
   end

endmodule
